### hdl/frp_pkg.sv
// Shared types, codes and constants of the FASTA record parser.
package frp_pkg;

  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned DefFifoDepth  = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_UPCASE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_VSET0  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_VSET1  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VSET2  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VSET3  = 3'd4;

  // Characters of interest
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Result kinds
  localparam logic [2:0] KIND_CONSUMED = 3'd0;
  localparam logic [2:0] KIND_RECORD   = 3'd1;
  localparam logic [2:0] KIND_LABEL    = 3'd2;
  localparam logic [2:0] KIND_META     = 3'd3;
  localparam logic [2:0] KIND_SITE     = 3'd4;
  localparam logic [2:0] KIND_END      = 3'd5;
  localparam logic [2:0] KIND_ERROR    = 3'd6;

  // Error codes
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NO_GT        = 4'd1;
  localparam logic [3:0] ERR_EMPTY_LABEL  = 4'd2;
  localparam logic [3:0] ERR_HEADER_END   = 4'd3;
  localparam logic [3:0] ERR_BAD_META     = 4'd4;
  localparam logic [3:0] ERR_BAD_SITE     = 4'd5;
  localparam logic [3:0] ERR_NO_FINAL_NL  = 4'd6;
  localparam logic [3:0] ERR_EMPTY_LINE   = 4'd7;
  localparam logic [3:0] ERR_EMPTY_SEQ    = 4'd8;

  typedef enum logic [2:0] {
    PH_START,
    PH_LABEL,
    PH_META,
    PH_HDRLINE,
    PH_COMMENT,
    PH_SEQ,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
  } out_item_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic       is_end;
    logic [7:0] raw_byte;
    logic [7:0] site_byte;
    logic       site_ok;
    logic       is_gt;
    logic       is_semi;
    logic       is_nl;
    logic       is_space;
    logic       graphic;
    logic       printable;
  } class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### hdl/fasta_record_parser_top.sv
// Top level of the FASTA record parser: front, queue and back tied together.
//
// Usage:
//   Feed the text stream one byte per transfer on the in channel
//   (in_valid_i / in_ready_o, payload in_item_i). Set end_of_input to close
//   the stream; its data byte is ignored. Every input transfer yields exactly
//   one result transfer on the out channel (out_valid_o / out_ready_i,
//   payload out_item_o) that tags the byte with a kind, an output byte and
//   an error code. Once an error is raised it sticks until reset.
//   Configuration (upcase enable, four 64-bit valid-site masks) is written
//   through cfg_we_i / cfg_idx_i / cfg_data_i while the parser is idle.
// Timing:
//   An accepted byte is queued; the back end pops it and registers its result.
//   One byte per cycle is sustained while out_ready_i is high; the record
//   state machine in the back end updates from the queue head on each pop.
// Reset:
//   Reset puts the parser at "expect record start" with no error, enables
//   upper-casing and marks all byte values valid. No clearing pass is needed.
// Stalls:
//   When out_ready_i is low the output register holds its result; the queue
//   absorbs up to FifoDepth more bytes before in_ready_o drops.
module fasta_record_parser_top #(
  parameter int unsigned FifoDepth = frp_pkg::DefFifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [frp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [frp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  frp_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output frp_pkg::out_item_t            out_item_o
);
  import frp_pkg::*;

  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;
  class_t     push_data;
  class_t     pop_data;

  // Classify each byte as it arrives
  frp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decouple acceptance from result delivery
  frp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  // Advance the record state machine and register the result
  frp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .item_i      (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### hdl/frp_front.sv
// Front end: configuration registers, input acceptance and byte classification.
module frp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [frp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [frp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  frp_pkg::in_item_t             in_item_i,
  input  frp_pkg::fifo_stat_t           fifo_stat_i,
  output logic                          push_o,
  output frp_pkg::class_t               push_data_o
);
  import frp_pkg::*;

  logic                 upcase_q;
  logic [4*CfgDataW-1:0] vset_q;
  logic [7:0]           b;
  logic [7:0]           c;
  logic                 lower;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upcase_q <= 1'b1;
      vset_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UPCASE: upcase_q <= cfg_data_i[0];
        CFG_VSET0:  vset_q[0*CfgDataW +: CfgDataW] <= cfg_data_i;
        CFG_VSET1:  vset_q[1*CfgDataW +: CfgDataW] <= cfg_data_i;
        CFG_VSET2:  vset_q[2*CfgDataW +: CfgDataW] <= cfg_data_i;
        CFG_VSET3:  vset_q[3*CfgDataW +: CfgDataW] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  assign b     = in_item_i.data_byte;
  assign lower = (b >= 8'h61) && (b <= 8'h7A);
  // Clearing bit 5 maps a-z onto A-Z
  assign c     = (upcase_q && lower) ? (b & 8'hDF) : b;

  always_comb begin
    push_data_o.is_end    = in_item_i.end_of_input;
    push_data_o.raw_byte  = b;
    push_data_o.site_byte = c;
    push_data_o.site_ok   = vset_q[c];
    push_data_o.is_gt     = (b == CHAR_GT);
    push_data_o.is_semi   = (b == CHAR_SEMI);
    push_data_o.is_nl     = (b == CHAR_NL);
    push_data_o.is_space  = (b == CHAR_SPACE);
    push_data_o.graphic   = (b >= 8'h21) && (b <= 8'h7E);
    push_data_o.printable = (b >= 8'h20) && (b <= 8'h7E);
  end

endmodule

### hdl/frp_fifo.sv
// Short queue of classified bytes between front and back.
module frp_fifo #(
  parameter int unsigned Depth = frp_pkg::DefFifoDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  frp_pkg::class_t      push_data_i,
  input  logic                 pop_i,
  output frp_pkg::class_t      pop_data_o,
  output frp_pkg::fifo_stat_t  stat_o
);
  import frp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  class_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign stat_o     = '{full: (cnt_q == FullCnt), empty: (cnt_q == '0)};

endmodule

### hdl/frp_back.sv
// Back end: record state machine, sticky error and output register.
module frp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frp_pkg::fifo_stat_t  fifo_stat_i,
  input  frp_pkg::class_t      item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output frp_pkg::out_item_t   out_item_o
);
  import frp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] sticky_q, sticky_d;
  logic       line_sites_q, line_sites_d;
  logic       rec_sites_q, rec_sites_d;
  logic       label_seen_q, label_seen_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, res;
  logic       go_seq;
  logic       line_sites_eff;

  assign pop_o = !fifo_stat_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d        = phase_q;
    sticky_d       = sticky_q;
    line_sites_d   = line_sites_q;
    rec_sites_d    = rec_sites_q;
    label_seen_d   = label_seen_q;
    res.kind       = KIND_CONSUMED;
    res.out_byte   = '0;
    res.error_code = ERR_NONE;
    go_seq         = 1'b0;
    line_sites_eff = line_sites_q;

    if (sticky_q != ERR_NONE) begin
      res.kind       = KIND_ERROR;
      res.error_code = sticky_q;
    end else begin
      unique case (phase_q)
        PH_START: begin
          if (item_i.is_end) begin
            phase_d  = PH_DONE;
            res.kind = KIND_END;
          end else if (!item_i.is_gt) begin
            sticky_d = ERR_NO_GT;
          end else begin
            phase_d      = PH_LABEL;
            label_seen_d = 1'b0;
            rec_sites_d  = 1'b0;
            line_sites_d = 1'b0;
            res.kind     = KIND_RECORD;
          end
        end
        PH_LABEL: begin
          if (!item_i.is_end && item_i.graphic) begin
            label_seen_d = 1'b1;
            res.kind     = KIND_LABEL;
            res.out_byte = item_i.raw_byte;
          end else if (!label_seen_q) begin
            sticky_d = ERR_EMPTY_LABEL;
          end else if (item_i.is_end) begin
            sticky_d = ERR_HEADER_END;
          end else if (item_i.is_space) begin
            phase_d = PH_META;
          end else if (item_i.is_nl) begin
            phase_d = PH_HDRLINE;
          end else begin
            sticky_d = ERR_HEADER_END;
          end
        end
        PH_META: begin
          if (item_i.is_end) begin
            sticky_d = ERR_BAD_META;
          end else if (item_i.is_nl) begin
            phase_d = PH_HDRLINE;
          end else if (item_i.printable) begin
            res.kind     = KIND_META;
            res.out_byte = item_i.raw_byte;
          end else begin
            sticky_d = ERR_BAD_META;
          end
        end
        PH_HDRLINE: begin
          if (!item_i.is_end && item_i.is_semi) begin
            phase_d = PH_COMMENT;
          end else begin
            phase_d        = PH_SEQ;
            line_sites_d   = 1'b0;
            line_sites_eff = 1'b0;
            go_seq         = 1'b1;
          end
        end
        PH_COMMENT: begin
          if (item_i.is_end) begin
            sticky_d = ERR_HEADER_END;
          end else if (item_i.is_nl) begin
            phase_d = PH_HDRLINE;
          end else if (!item_i.printable) begin
            sticky_d = ERR_HEADER_END;
          end
        end
        PH_SEQ: begin
          go_seq = 1'b1;
        end
        default: begin
          phase_d  = PH_DONE;
          res.kind = KIND_END;
        end
      endcase

      if (go_seq) begin
        priority if (!line_sites_eff && (item_i.is_end || item_i.is_gt)) begin
          if (!rec_sites_q) begin
            sticky_d = ERR_EMPTY_SEQ;
          end else if (item_i.is_end) begin
            phase_d  = PH_DONE;
            res.kind = KIND_END;
          end else begin
            phase_d      = PH_LABEL;
            label_seen_d = 1'b0;
            rec_sites_d  = 1'b0;
            res.kind     = KIND_RECORD;
          end
        end else if (!line_sites_eff && item_i.is_nl) begin
          sticky_d = ERR_EMPTY_LINE;
        end else if (line_sites_eff && item_i.is_end) begin
          sticky_d = ERR_NO_FINAL_NL;
        end else if (line_sites_eff && item_i.is_nl) begin
          line_sites_d = 1'b0;
        end else if (!item_i.site_ok) begin
          sticky_d = ERR_BAD_SITE;
        end else begin
          line_sites_d = 1'b1;
          rec_sites_d  = 1'b1;
          phase_d      = PH_SEQ;
          res.kind     = KIND_SITE;
          res.out_byte = item_i.site_byte;
        end
      end

      // A freshly raised error answers with its own code
      if (sticky_d != ERR_NONE) begin
        res.kind       = KIND_ERROR;
        res.out_byte   = '0;
        res.error_code = sticky_d;
      end
    end
  end

  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      sticky_q     <= ERR_NONE;
      line_sites_q <= 1'b0;
      rec_sites_q  <= 1'b0;
      label_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q      <= phase_d;
        sticky_q     <= sticky_d;
        line_sites_q <= line_sites_d;
        rec_sites_q  <= rec_sites_d;
        label_seen_q <= label_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### sim/tb_fasta_record_parser_top.sv
// Self-checking testbench of the FASTA record parser: byte stream in, tagged bytes out.
`timescale 1ns / 100ps

module tb_fasta_record_parser_top;
  import frp_pkg::*;

  // Random bytes sent under each register setting.
  localparam int unsigned PhaseItems = 475;
  // Cycles that the result side holds off once, to fill the parser up.
  localparam int unsigned HoldCycles = 50;
  localparam logic [63:0] AllOnes = '1;
  // A, C, G, N and T among byte values 64 to 127
  localparam logic [63:0] NucMask = 64'h0000_0000_0010_408A;

  // How the stream is closed. Errors stick until reset and reset comes only once,
  // so the run can close in one of these ways only; the seed picks which.
  typedef enum int {
    CLOSE_CLEAN,
    CLOSE_EMPTY_LABEL,
    CLOSE_END_IN_LABEL,
    CLOSE_BAD_HEADER,
    CLOSE_BAD_META,
    CLOSE_BAD_SITE,
    CLOSE_NO_FINAL_NL,
    CLOSE_EMPTY_LINE,
    CLOSE_EMPTY_SEQ,
    CLOSE_BAD_COMMENT
  } close_e;

  // Tags every transferred byte as the parser should, and checks the tags that come out.
  class fasta_scoreboard;
    logic            upcase;
    logic [63:0]     vset [4];
    phase_e          ph;
    logic [3:0]      err_code;
    logic            line_sites;
    logic            rec_sites;
    logic            have_label;
    out_item_t       pending_tags [$];
    int unsigned     errors;

    function new();
      upcase = 1'b1;
      foreach (vset[i]) vset[i] = '1;
      ph = PH_START;
      err_code = ERR_NONE;
      line_sites = 1'b0;
      rec_sites = 1'b0;
      have_label = 1'b0;
      errors = 0;
    endfunction

    function void set_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_UPCASE: upcase = data[0];
        CFG_VSET0: vset[0] = data;
        CFG_VSET1: vset[1] = data;
        CFG_VSET2: vset[2] = data;
        CFG_VSET3: vset[3] = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] fold_case(logic [7:0] b);
      return (upcase && b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    endfunction

    function logic site_accepts(logic [7:0] b);
      logic [7:0] c;
      c = fold_case(b);
      return vset[c[7:6]][c[5:0]];
    endfunction

    function out_item_t tag(logic [2:0] k, logic [7:0] b, logic [3:0] e);
      out_item_t r;
      r.kind = k;
      r.out_byte = b;
      r.error_code = e;
      return r;
    endfunction

    function out_item_t raise(logic [3:0] code);
      err_code = code;
      return tag(KIND_ERROR, 8'h00, code);
    endfunction

    function out_item_t take_site(logic [7:0] b);
      if (!site_accepts(b)) return raise(ERR_BAD_SITE);
      line_sites = 1'b1;
      rec_sites = 1'b1;
      ph = PH_SEQ;
      return tag(KIND_SITE, fold_case(b), ERR_NONE);
    endfunction

    function out_item_t tag_byte(in_item_t it);
      logic [7:0] b;
      logic       fin;
      logic       graphic;
      logic       printable;
      b = it.data_byte;
      fin = it.end_of_input;
      graphic = b >= 8'h21 && b <= 8'h7E;
      printable = b >= 8'h20 && b <= 8'h7E;
      if (err_code != ERR_NONE) return tag(KIND_ERROR, 8'h00, err_code);
      case (ph)
        PH_START: begin
          if (fin) begin
            ph = PH_DONE;
            return tag(KIND_END, 8'h00, ERR_NONE);
          end
          if (b != CHAR_GT) return raise(ERR_NO_GT);
          ph = PH_LABEL;
          have_label = 1'b0;
          rec_sites = 1'b0;
          line_sites = 1'b0;
          return tag(KIND_RECORD, 8'h00, ERR_NONE);
        end
        PH_LABEL: begin
          if (!fin && graphic) begin
            have_label = 1'b1;
            return tag(KIND_LABEL, b, ERR_NONE);
          end
          if (!have_label) return raise(ERR_EMPTY_LABEL);
          if (fin) return raise(ERR_HEADER_END);
          if (b == CHAR_SPACE) begin
            ph = PH_META;
            return tag(KIND_CONSUMED, 8'h00, ERR_NONE);
          end
          if (b == CHAR_NL) begin
            ph = PH_HDRLINE;
            return tag(KIND_CONSUMED, 8'h00, ERR_NONE);
          end
          return raise(ERR_HEADER_END);
        end
        PH_META: begin
          if (fin) return raise(ERR_BAD_META);
          if (b == CHAR_NL) begin
            ph = PH_HDRLINE;
            return tag(KIND_CONSUMED, 8'h00, ERR_NONE);
          end
          if (printable) return tag(KIND_META, b, ERR_NONE);
          return raise(ERR_BAD_META);
        end
        PH_HDRLINE: begin
          if (!fin && b == CHAR_SEMI) begin
            ph = PH_COMMENT;
            return tag(KIND_CONSUMED, 8'h00, ERR_NONE);
          end
          ph = PH_SEQ;
          line_sites = 1'b0;
        end
        PH_COMMENT: begin
          if (fin) return raise(ERR_HEADER_END);
          if (b == CHAR_NL) begin
            ph = PH_HDRLINE;
            return tag(KIND_CONSUMED, 8'h00, ERR_NONE);
          end
          if (printable) return tag(KIND_CONSUMED, 8'h00, ERR_NONE);
          return raise(ERR_HEADER_END);
        end
        PH_SEQ: ;
        default: begin
          ph = PH_DONE;
          return tag(KIND_END, 8'h00, ERR_NONE);
        end
      endcase
      // sequence lines
      if (!line_sites) begin
        if (fin || b == CHAR_GT) begin
          if (!rec_sites) return raise(ERR_EMPTY_SEQ);
          if (fin) begin
            ph = PH_DONE;
            return tag(KIND_END, 8'h00, ERR_NONE);
          end
          ph = PH_LABEL;
          have_label = 1'b0;
          rec_sites = 1'b0;
          return tag(KIND_RECORD, 8'h00, ERR_NONE);
        end
        if (b == CHAR_NL) return raise(ERR_EMPTY_LINE);
        return take_site(b);
      end
      if (fin) return raise(ERR_NO_FINAL_NL);
      if (b == CHAR_NL) begin
        line_sites = 1'b0;
        return tag(KIND_CONSUMED, 8'h00, ERR_NONE);
      end
      return take_site(b);
    endfunction

    function void note_byte(in_item_t it);
      pending_tags.insert(pending_tags.size(), tag_byte(it));
    endfunction

    function int unsigned pending_count();
      return pending_tags.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_tag(out_item_t got);
      out_item_t want;
      if (pending_tags.size() == 0) begin
        report($sformatf("result kind %0d byte %02h code %0d with no byte pending",
                         got.kind, got.out_byte, got.error_code));
        return;
      end
      want = pending_tags.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
    endtask
  endclass

  // Every input of the parser has a known value from time zero.
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = CFG_UPCASE;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  in_item_t            in_item_i  = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  out_item_t           out_item_o;

  fasta_scoreboard sb;
  int unsigned     items_sent = 0;
  bit              tx_gaps = 1'b0;   // sender may idle between transfers
  bit              rx_gaps = 1'b0;   // result side may stall
  bit              hold_req = 1'b0;  // ask the result side for one long hold-off
  int unsigned     hold_left = 0;
  int unsigned     stall_left = 0;

  fasta_record_parser_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: drive ready at the falling edge. A requested hold-off is counted
  // here and takes priority; otherwise stall in short random bursts when enabled.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watch both channels at the rising edge: every input transfer queues its
  // expected tag, every output transfer is checked against the oldest one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_item_i);
      if (out_valid_o && out_ready_i) sb.check_tag(out_item_o);
    end
  end

  // Offer one byte and hold it until the transfer. Called at a falling edge and
  // returns at the falling edge after the transfer with valid still high, so the
  // next call can follow straight on.
  task automatic push(input logic [7:0] b, input logic fin);
    in_item_t it;
    it.data_byte = b;
    it.end_of_input = fin;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Pick a byte that the current setting takes as a site. At a line start a '>'
  // would open the next record, and a newline is never a site.
  function automatic logic [7:0] pick_site(input logic line_start);
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (!sb.site_accepts(b) || b == CHAR_NL || (line_start && b == CHAR_GT));
    return b;
  endfunction

  task automatic push_label();
    repeat ($urandom_range(1, 6)) push(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
  endtask

  // One well-formed record with random content: header, optional metadata,
  // up to two comment lines, one to three sequence lines.
  task automatic push_record();
    push(CHAR_GT, 1'b0);
    push_label();
    if ($urandom_range(0, 1)) begin
      push(CHAR_SPACE, 1'b0);
      repeat ($urandom_range(0, 6)) push(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
    end
    push(CHAR_NL, 1'b0);
    repeat ($urandom_range(0, 2)) begin
      push(CHAR_SEMI, 1'b0);
      repeat ($urandom_range(0, 5)) push(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      push(CHAR_NL, 1'b0);
    end
    repeat ($urandom_range(1, 3)) begin
      push(pick_site(1'b1), 1'b0);
      repeat ($urandom_range(0, 11)) push(pick_site(1'b0), 1'b0);
      push(CHAR_NL, 1'b0);
    end
  endtask

  // Wait until every expected tag has come, plus the parser's latency.
  task automatic settle();
    while (sb.pending_count() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Write all five registers back to back, then drop the write enable.
  task automatic write_cfg(input logic up, input logic [63:0] m0, m1, m2, m3);
    logic [CfgIdxW-1:0]  idx [5];
    logic [CfgDataW-1:0] val [5];
    idx = '{CFG_UPCASE, CFG_VSET0, CFG_VSET1, CFG_VSET2, CFG_VSET3};
    val = '{{63'd0, up}, m0, m1, m2, m3};
    foreach (idx[i]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      sb.set_cfg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Quiesce, load a new setting, then stream random records. With hold set,
  // the result side holds off once halfway through while bytes keep coming.
  task automatic run_phase(input logic up, input logic [63:0] m0, m1, m2, m3,
                           input bit hold);
    int unsigned stop_at;
    in_valid_i <= 1'b0;
    settle();
    write_cfg(up, m0, m1, m2, m3);
    stop_at = items_sent + PhaseItems;
    while (items_sent < stop_at) begin
      if (hold && items_sent + PhaseItems / 2 > stop_at) begin
        hold_req = 1'b1;
        hold = 1'b0;
      end
      push_record();
    end
  endtask

  // Close the stream from a sequence line start, cleanly or with one of the
  // malformed endings, then send a few more items that must repeat the verdict.
  task automatic close_stream();
    close_e how;
    logic   coin;
    how = close_e'($urandom_range(CLOSE_CLEAN, CLOSE_BAD_COMMENT));
    coin = 1'($urandom_range(0, 1));
    case (how)
      CLOSE_CLEAN: push(8'($urandom_range(0, 255)), 1'b1);
      CLOSE_EMPTY_LABEL: begin
        push(CHAR_GT, 1'b0);
        if (coin) push(8'($urandom_range(0, 255)), 1'b1);
        else push(CHAR_NL, 1'b0);
      end
      CLOSE_END_IN_LABEL: begin
        push(CHAR_GT, 1'b0);
        push_label();
        push(8'($urandom_range(0, 255)), 1'b1);
      end
      CLOSE_BAD_HEADER: begin
        push(CHAR_GT, 1'b0);
        push_label();
        push(coin ? 8'h09 : 8'($urandom_range(8'h7F, 8'hFF)), 1'b0);
      end
      CLOSE_BAD_META: begin
        push(CHAR_GT, 1'b0);
        push_label();
        push(CHAR_SPACE, 1'b0);
        repeat ($urandom_range(0, 3)) push(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        if (coin) push(8'($urandom_range(0, 255)), 1'b1);
        else push(8'h7F, 1'b0);
      end
      CLOSE_BAD_SITE: begin
        if (coin) push(pick_site(1'b1), 1'b0);
        push(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
      end
      CLOSE_NO_FINAL_NL: begin
        push(pick_site(1'b1), 1'b0);
        repeat ($urandom_range(0, 3)) push(pick_site(1'b0), 1'b0);
        push(8'($urandom_range(0, 255)), 1'b1);
      end
      CLOSE_EMPTY_LINE: push(CHAR_NL, 1'b0);
      CLOSE_EMPTY_SEQ: begin
        push(CHAR_GT, 1'b0);
        push_label();
        push(CHAR_NL, 1'b0);
        if (coin) push(8'($urandom_range(0, 255)), 1'b1);
        else push(CHAR_GT, 1'b0);
      end
      default: begin
        push(CHAR_GT, 1'b0);
        push_label();
        push(CHAR_NL, 1'b0);
        push(CHAR_SEMI, 1'b0);
        if (coin) push(8'($urandom_range(0, 255)), 1'b1);
        else push(8'h01, 1'b0);
      end
    endcase
    repeat (6) push(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    // Opening record under the reset setting: label and metadata extremes,
    // two comment lines (one empty), case folding at and beyond a..z, bytes
    // 00 and FF as sites, '>' and ';' inside a sequence line, a second line.
    logic [7:0] opening [24];
    sb = new();
    opening = '{8'h3E, 8'h21, 8'h7E, 8'h20, 8'h20, 8'h7E, 8'h0A,
                8'h3B, 8'h20, 8'h7E, 8'h0A, 8'h3B, 8'h0A,
                8'h61, 8'h7A, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h3E, 8'h3B, 8'h0A,
                8'h63, 8'h0A};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (opening[i]) push(opening[i], 1'b0);

    // no folding, control bytes invalid, both sides idling
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_phase(1'b0, '0, AllOnes, {$urandom, $urandom}, AllOnes, 1'b0);
    // nucleotide letters only among bytes 64..127, bytes 0..63 and high bytes partly; long hold-off
    run_phase(1'b1, {$urandom, $urandom}, NucMask, '0, {$urandom, $urandom}, 1'b1);
    // everything valid, only the sender idles
    rx_gaps = 1'b0;
    run_phase(1'b1, AllOnes, AllOnes, AllOnes, AllOnes, 1'b0);
    // last stretch at full rate; top quarter invalid so a bad site can close it
    tx_gaps = 1'b0;
    run_phase(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom},
              AllOnes, '0, 1'b0);

    close_stream();
    in_valid_i <= 1'b0;
    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hdl/frp_pkg.sv
hdl/frp_front.sv
hdl/frp_fifo.sv
hdl/frp_back.sv
hdl/fasta_record_parser_top.sv
sim/tb_fasta_record_parser_top.sv
